@@ rtl/core/rrqs_pkg.sv @@
// shared constants, codes and types of the round robin quantum scheduler
package rrqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int ID_W      = 8;
  localparam int BURST_W   = 16;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int WAIT_W    = 32;
  localparam int CNT16_W   = 16;
  localparam int T36_W     = 36;
  localparam int SLICE_W   = 8;
  localparam int OVH_W     = CNT16_W + CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_SLICE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_OVH = 1'b1;

  localparam logic [CFG_W-1:0] TIME_SLICE_RST = 8'd4;
  localparam logic [CFG_W-1:0] SWITCH_OVH_RST = 8'd0;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [T36_W-1:0] T36_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ARRIVE, ST_SEL, ST_LOAD, ST_AGE_RD, ST_AGE_WR,
    ST_MUL, ST_SUM, ST_FIN, ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic arrive;
    logic sel;
    logic load;
    logic age_rd;
    logic age_wr;
    logic mul;
    logic sum;
    logic fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic walk_done;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic               queue_full;
    logic               busy_res;
    logic [ID_W-1:0]    running_id;
    logic               finished;
    logic [T36_W-1:0]   done_time;
    logic [T36_W-1:0]   first_run_delay;
    logic [WAIT_W-1:0]  waiting_ticks;
    logic [CNT16_W-1:0] switches_seen;
    logic [CNT16_W-1:0] preemptions;
    logic [CNT16_W-1:0] total_switches;
  } res_t;

endpackage

@@ rtl/core/rrqs_if.sv @@
// channel interfaces: job input, result output and register write
interface rrqs_in_if;
  import rrqs_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [ID_W-1:0]    job_id;
  logic [BURST_W-1:0] burst_length;
  modport source(output valid, action, job_id, burst_length, input ready);
  modport sink(input valid, action, job_id, burst_length, output ready);
endinterface

interface rrqs_out_if;
  import rrqs_pkg::*;
  logic               valid;
  logic               ready;
  logic               queue_full;
  logic               busy_res;
  logic [ID_W-1:0]    running_id;
  logic               finished;
  logic [T36_W-1:0]   done_time;
  logic [T36_W-1:0]   first_run_delay;
  logic [WAIT_W-1:0]  waiting_ticks;
  logic [CNT16_W-1:0] switches_seen;
  logic [CNT16_W-1:0] preemptions;
  logic [CNT16_W-1:0] total_switches;
  modport source(output valid, queue_full, busy_res, running_id, finished, done_time,
                 first_run_delay, waiting_ticks, switches_seen, preemptions, total_switches,
                 input ready);
  modport sink(input valid, queue_full, busy_res, running_id, finished, done_time,
               first_run_delay, waiting_ticks, switches_seen, preemptions, total_switches,
               output ready);
endinterface

interface rrqs_cfg_if;
  import rrqs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/rrqs_ctrl.sv @@
// scheduler sequencer: steps one item through arrive, or through select, aging walk and run
module rrqs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  input  rrqs_pkg::sts_t sts,
  output rrqs_pkg::cmd_t cmd,
  output logic           in_ready
);
  import rrqs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_action == ACT_TICK) ? ST_SEL : ST_ARRIVE;
      end
      ST_ARRIVE: state_nxt = ST_DONE;
      ST_SEL:    state_nxt = sts.pop ? ST_LOAD : ST_AGE_RD;
      ST_LOAD:   state_nxt = ST_AGE_RD;
      ST_AGE_RD: state_nxt = sts.walk_done ? ST_MUL : ST_AGE_WR;
      ST_AGE_WR: state_nxt = ST_AGE_RD;
      ST_MUL:    state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_ARRIVE: cmd.arrive = 1'b1;
      ST_SEL:    cmd.sel    = 1'b1;
      ST_LOAD:   cmd.load   = 1'b1;
      ST_AGE_RD: cmd.age_rd = !sts.walk_done;
      ST_AGE_WR: cmd.age_wr = 1'b1;
      ST_MUL:    cmd.mul    = 1'b1;
      ST_SUM:    cmd.sum    = 1'b1;
      ST_FIN:    cmd.fin    = 1'b1;
      ST_DONE:   cmd.emit   = !sts.out_busy;
      default:   cmd        = '0;
    endcase
  end

endmodule

@@ rtl/core/rrqs_datapath.sv @@
// scheduler datapath: ready queue memory, running job, counters and result register
module rrqs_datapath #(
  parameter int QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = rrqs_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rrqs_pkg::cmd_t                 cmd,
  output rrqs_pkg::sts_t                 sts,
  input  logic [rrqs_pkg::ID_W-1:0]      in_job_id,
  input  logic [rrqs_pkg::BURST_W-1:0]   in_burst_length,
  input  logic                           cfg_we,
  input  logic [rrqs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrqs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output rrqs_pkg::res_t                 out_res
);
  import rrqs_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = ((TIME_BITS + 4 > T36_W) ? TIME_BITS + 4 : T36_W) + 1;
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_C1 = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [BURST_W-1:0]   remaining;
    logic [TIME_BITS-1:0] arrival;
    logic [WAIT_W-1:0]    waiting;
    logic [T36_W-1:0]     response;
    logic                 response_set;
    logic [CNT16_W-1:0]   switches;
    logic [CNT16_W-1:0]   preempts;
  } job_t;

  job_t mem [QUEUE_DEPTH];
  job_t rd_q;

  logic [CFG_W-1:0]     ts_r, ovh_cfg_r;
  logic [ID_W-1:0]      id_in_r;
  logic [BURST_W-1:0]   burst_in_r;
  logic [IDX_W-1:0]     head_r, walk_ptr_r;
  logic [CNT_W-1:0]     count_r, walk_k_r;
  logic                 active_r, dispatch_r, rotate_r;
  logic [TIME_BITS-1:0] tick_r;
  logic [SLICE_W-1:0]   slice_r;
  logic [CNT16_W-1:0]   swtot_r;
  job_t                 cur_r;
  logic [OVH_W-1:0]     ovhp_r;
  logic [SW-1:0]        start_r;
  res_t                 res_r, out_r;
  logic                 out_valid_r;

  logic                 full, pop;
  logic [CNT_W:0]       tail_sum, tail_wrap;
  logic [IDX_W-1:0]     tail_idx, head_inc, walk_inc;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_wa, mem_ra;
  job_t                 mem_wd, new_job, cur_nxt;
  res_t                 res_nxt;
  logic [SW-1:0]        arr16, resp_raw;
  logic [T36_W-1:0]     resp_val;

  function automatic logic [T36_W-1:0] sat36(input logic [SW-1:0] v);
    return (v > SW'(T36_MAX)) ? T36_MAX : v[T36_W-1:0];
  endfunction

  function automatic logic [CNT16_W-1:0] sat16(input logic [CNT16_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign full      = (count_r == DEPTH_C);
  assign pop       = (count_r != '0) && (!active_r || (slice_r >= ts_r));
  assign tail_sum  = {1'b0, count_r} + (CNT_W + 1)'(head_r);
  assign tail_wrap = (tail_sum >= DEPTH_C1) ? tail_sum - DEPTH_C1 : tail_sum;
  assign tail_idx  = tail_wrap[IDX_W-1:0];
  assign head_inc  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign walk_inc  = (walk_ptr_r == LAST_IDX) ? '0 : walk_ptr_r + 1'b1;

  assign sts.pop       = pop;
  assign sts.walk_done = (walk_k_r == count_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    new_job           = '0;
    new_job.id        = id_in_r;
    new_job.remaining = (burst_in_r == '0) ? BURST_W'(1) : burst_in_r;
    new_job.arrival   = tick_r;
  end

  // one write port: arrival, rotated job at the tail, or an aged entry
  always_comb begin
    mem_we = (cmd.arrive && !full) || (cmd.load && rotate_r) || cmd.age_wr;
    mem_wa = cmd.age_wr ? walk_ptr_r : tail_idx;
    mem_wd = new_job;
    if (cmd.load) begin
      mem_wd          = cur_r;
      mem_wd.preempts = sat16(cur_r.preempts);
    end else if (cmd.age_wr) begin
      mem_wd         = rd_q;
      mem_wd.waiting = (&rd_q.waiting) ? rd_q.waiting : rd_q.waiting + 1'b1;
      if (rotate_r) mem_wd.switches = sat16(rd_q.switches);
    end
    mem_re = cmd.sel || cmd.age_rd;
    mem_ra = cmd.sel ? head_r : walk_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_comb begin
    arr16    = SW'({cur_r.arrival, 4'b0000});
    resp_raw = start_r - arr16;
    if (cur_r.response_set) resp_val = cur_r.response;
    else if (start_r >= arr16) resp_val = sat36(resp_raw);
    else resp_val = '0;
  end

  always_comb begin
    cur_nxt = cur_r;
    if (cmd.load) begin
      cur_nxt = rd_q;
      if (rotate_r) cur_nxt.switches = sat16(rd_q.switches);
    end else if (cmd.fin && active_r) begin
      cur_nxt.response     = resp_val;
      cur_nxt.response_set = 1'b1;
      cur_nxt.remaining    = cur_r.remaining - 1'b1;
    end
  end

  always_comb begin
    res_nxt                = '0;
    res_nxt.total_switches = swtot_r;
    if (cmd.arrive) begin
      res_nxt.queue_full = full;
    end else if (active_r) begin
      res_nxt.busy_res   = 1'b1;
      res_nxt.running_id = cur_r.id;
      if (cur_r.remaining == BURST_W'(1)) begin
        res_nxt.finished        = 1'b1;
        res_nxt.done_time       = sat36(start_r + SW'(16));
        res_nxt.first_run_delay = resp_val;
        res_nxt.waiting_ticks   = cur_r.waiting;
        res_nxt.switches_seen   = cur_r.switches;
        res_nxt.preemptions     = cur_r.preempts;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r      <= TIME_SLICE_RST;
      ovh_cfg_r <= SWITCH_OVH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_SLICE: ts_r      <= cfg_data;
        REG_SWITCH_OVH: ovh_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      active_r    <= 1'b0;
      tick_r      <= '0;
      slice_r     <= '0;
      swtot_r     <= '0;
      dispatch_r  <= 1'b0;
      rotate_r    <= 1'b0;
      walk_ptr_r  <= '0;
      walk_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.arrive && !full) count_r <= count_r + 1'b1;
      if (cmd.sel) begin
        dispatch_r <= pop && !active_r;
        rotate_r   <= pop && active_r;
        walk_ptr_r <= head_r;
        walk_k_r   <= '0;
      end
      if (cmd.load) begin
        head_r     <= head_inc;
        walk_ptr_r <= head_inc;
        slice_r    <= '0;
        if (dispatch_r) begin
          count_r  <= count_r - 1'b1;
          active_r <= 1'b1;
        end
        if (rotate_r) swtot_r <= sat16(swtot_r);
      end
      if (cmd.age_wr) begin
        walk_ptr_r <= walk_inc;
        walk_k_r   <= walk_k_r + 1'b1;
      end
      if (cmd.fin) begin
        tick_r <= tick_r + 1'b1;
        if (!(&slice_r)) slice_r <= slice_r + 1'b1;
        if (active_r && (cur_r.remaining == BURST_W'(1))) active_r <= 1'b0;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      id_in_r    <= in_job_id;
      burst_in_r <= in_burst_length;
    end
    cur_r <= cur_nxt;
    if (cmd.mul) ovhp_r <= OVH_W'(swtot_r) * OVH_W'(ovh_cfg_r);
    if (cmd.sum) start_r <= SW'({tick_r, 4'b0000}) + SW'(ovhp_r);
    if (cmd.arrive || cmd.fin) res_r <= res_nxt;
    if (cmd.emit) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ rtl/core/round_robin_quantum_scheduler_core.sv @@
// round robin quantum scheduler top level
//
//   port    dir  role
//   in_ch   in   job items: arrive a job or advance one tick
//   out_ch  out  one result per item
//   cfg_ch  in   register writes: time_slice, switch_overhead
//
// an arrive passes the arrive state and the result register on to the output
// register; a tick passes select, a load when a job is dispatched or rotated,
// the aging walk that reads and rewrites one queued entry at a time, then mul, sum and fin.
// the next input transfer can come in the cycle after the result is loaded.
// reset is synchronous and clears all control state; the queue needs no clear.
// a result waits in the output register while the next item is taken; only
// the write of a further result stalls until that register frees.
module round_robin_quantum_scheduler_core #(
  parameter int QUEUE_DEPTH = rrqs_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = rrqs_pkg::TIME_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rrqs_in_if.sink     in_ch,
  rrqs_out_if.source  out_ch,
  rrqs_cfg_if.sink    cfg_ch
);
  import rrqs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  assign cfg_ch.ready = 1'b1;

  rrqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_action(in_ch.action),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  rrqs_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_job_id      (in_ch.job_id),
    .in_burst_length(in_ch.burst_length),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_res        (res)
  );

  assign out_ch.queue_full      = res.queue_full;
  assign out_ch.busy_res        = res.busy_res;
  assign out_ch.running_id      = res.running_id;
  assign out_ch.finished        = res.finished;
  assign out_ch.done_time       = res.done_time;
  assign out_ch.first_run_delay = res.first_run_delay;
  assign out_ch.waiting_ticks   = res.waiting_ticks;
  assign out_ch.switches_seen   = res.switches_seen;
  assign out_ch.preemptions     = res.preemptions;
  assign out_ch.total_switches  = res.total_switches;

endmodule

@@ rtl/core/rrqs_checker.sv @@
// port-level checks of the scheduler results, bound to the top level
module rrqs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         queue_full,
  input logic                         busy_res,
  input logic                         finished,
  input logic [rrqs_pkg::ID_W-1:0]    running_id,
  input logic [rrqs_pkg::CNT16_W-1:0] total_switches
);
  import rrqs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(total_switches) && $stable(running_id))
    else $error("result changed while stalled");

  // a refused arrive never reports a running job
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && queue_full |-> !busy_res && !finished)
    else $error("refused arrive carries job figures");

  // only a job that ran can finish
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && finished |-> busy_res)
    else $error("finish without a running job");

  // idle tick shows no job id
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> running_id == '0)
    else $error("job id shown on idle result");

endmodule

bind round_robin_quantum_scheduler_core rrqs_checker u_rrqs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .queue_full    (out_ch.queue_full),
  .busy_res      (out_ch.busy_res),
  .finished      (out_ch.finished),
  .running_id    (out_ch.running_id),
  .total_switches(out_ch.total_switches)
);

@@ bench/tb.sv @@
// self-checking bench for the round robin quantum scheduler core
`timescale 1ns / 1ps

module tb;
  import rrqs_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_GAP   = 2 * DEPTH + 40;
  localparam int HOLD_CYCLES = 600;
  localparam int RAND_ITEMS  = 245;

  typedef struct {
    logic               action;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst;
  } job_req_t;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] remaining;
    logic [31:0]        arrival;
    logic [WAIT_W-1:0]  waited;
    logic [T36_W-1:0]   response;
    bit                 response_set;
    logic [CNT16_W-1:0] switches;
    logic [CNT16_W-1:0] preempts;
  } sched_job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rrqs_in_if  in_ch();
  rrqs_out_if out_ch();
  rrqs_cfg_if cfg_ch();

  round_robin_quantum_scheduler_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #2 clk = ~clk;

  // scheduler mirror
  sched_job_t         ready_slots [DEPTH];
  int                 q_head;
  int                 q_count;
  sched_job_t         running;
  bit                 running_valid;
  logic [31:0]        tick_cnt;
  logic [SLICE_W-1:0] slice_cnt;
  logic [CNT16_W-1:0] switch_cnt;
  logic [CFG_W-1:0]   quantum;
  logic [CFG_W-1:0]   overhead;

  job_req_t job_q [$];
  res_t     sched_results [$];
  job_req_t cur_req;
  int       acc_in;
  int       acc_out;
  int       err_cnt;
  int       hold_left;
  bit       hold_done;

  function automatic logic [CNT16_W-1:0] inc16(logic [CNT16_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [T36_W-1:0] clamp36(logic [63:0] v);
    return (v > 64'(T36_MAX)) ? T36_MAX : v[T36_W-1:0];
  endfunction

  task automatic sched_predict(input job_req_t req);
    res_t        r;
    sched_job_t  nj;
    sched_job_t  nxt;
    bit          rotated;
    logic [63:0] start;
    logic [63:0] arr16;
    int          slot;
    r = '0;
    rotated = 1'b0;
    if (req.action == ACT_ARRIVE) begin
      if (q_count >= DEPTH) begin
        r.queue_full = 1'b1;
      end else begin
        nj = '{default: '0};
        nj.id = req.job_id;
        nj.remaining = (req.burst == '0) ? BURST_W'(1) : req.burst;
        nj.arrival = tick_cnt;
        ready_slots[(q_head + q_count) % DEPTH] = nj;
        q_count++;
      end
    end else begin
      if (!running_valid) begin
        if (q_count > 0) begin
          running = ready_slots[q_head];
          q_head = (q_head + 1) % DEPTH;
          q_count--;
          running_valid = 1'b1;
          slice_cnt = '0;
        end
      end else if (slice_cnt >= quantum && q_count > 0) begin
        nxt = ready_slots[q_head];
        q_head = (q_head + 1) % DEPTH;
        q_count--;
        running.preempts = inc16(running.preempts);
        ready_slots[(q_head + q_count) % DEPTH] = running;
        q_count++;
        running = nxt;
        switch_cnt = inc16(switch_cnt);
        slice_cnt = '0;
        running.switches = inc16(running.switches);
        rotated = 1'b1;
      end
      for (int k = 0; k < q_count; k++) begin
        slot = (q_head + k) % DEPTH;
        if (ready_slots[slot].waited != '1)
          ready_slots[slot].waited = ready_slots[slot].waited + 1'b1;
        if (rotated)
          ready_slots[slot].switches = inc16(ready_slots[slot].switches);
      end
      if (running_valid) begin
        start = (64'(tick_cnt) << 4) + 64'(switch_cnt) * 64'(overhead);
        r.busy_res = 1'b1;
        r.running_id = running.id;
        if (!running.response_set) begin
          arr16 = 64'(running.arrival) << 4;
          running.response = (start >= arr16) ? clamp36(start - arr16) : '0;
          running.response_set = 1'b1;
        end
        running.remaining = running.remaining - 1'b1;
        if (running.remaining == '0) begin
          r.finished = 1'b1;
          r.done_time = clamp36(start + 64'd16);
          r.first_run_delay = running.response;
          r.waiting_ticks = running.waited;
          r.switches_seen = running.switches;
          r.preemptions = running.preempts;
          running_valid = 1'b0;
        end
      end
      tick_cnt = tick_cnt + 1'b1;
      if (slice_cnt != '1) slice_cnt = slice_cnt + 1'b1;
    end
    r.total_switches = switch_cnt;
    sched_results.push_back(r);
  endtask

  task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s expected %0d got %0d", nm, e, a);
      err_cnt++;
    end
  endtask

  // input driver
  always @(posedge clk) begin : drive_jobs
    bit fire;
    int idle_pct;
    if (rst_n) begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        sched_predict(cur_req);
        acc_in++;
      end
      idle_pct = (acc_in < 420) ? 31 : (acc_in < 840) ? 67 : 0;
      if (!in_ch.valid || fire) begin
        if (job_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = job_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= cur_req.action;
          in_ch.job_id <= cur_req.job_id;
          in_ch.burst_length <= cur_req.burst;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, with one long hold-off to back the block up
  always @(posedge clk) begin : watch_results
    res_t e;
    int   idle_pct;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        acc_out++;
        if (sched_results.size() == 0) begin
          $error("unexpected result transfer");
          err_cnt++;
        end else begin
          e = sched_results.pop_front();
          check_field("queue_full", e.queue_full, out_ch.queue_full);
          check_field("busy_res", e.busy_res, out_ch.busy_res);
          check_field("running_id", e.running_id, out_ch.running_id);
          check_field("finished", e.finished, out_ch.finished);
          check_field("done_time", e.done_time, out_ch.done_time);
          check_field("first_run_delay", e.first_run_delay, out_ch.first_run_delay);
          check_field("waiting_ticks", e.waiting_ticks, out_ch.waiting_ticks);
          check_field("switches_seen", e.switches_seen, out_ch.switches_seen);
          check_field("preemptions", e.preemptions, out_ch.preemptions);
          check_field("total_switches", e.total_switches, out_ch.total_switches);
        end
      end
      if (!hold_done && acc_out >= 200) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        idle_pct = (acc_in < 420) ? 67 : (acc_in < 840) ? 31 : 0;
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic job_req_t mk_req(logic act, logic [ID_W-1:0] id, logic [BURST_W-1:0] b);
    job_req_t j;
    j.action = act;
    j.job_id = id;
    j.burst = b;
    return j;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_TIME_SLICE) quantum = val;
    else overhead = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (job_q.size() != 0 || in_ch.valid || sched_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    int               roll;
    logic [BURST_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 74) begin
        job_q.push_back(mk_req(ACT_TICK, ID_W'($urandom), BURST_W'($urandom)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 80) b = BURST_W'($urandom_range(1, 3));
        else if (roll < 97) b = BURST_W'($urandom_range(4, 12));
        else b = '0;
        job_q.push_back(mk_req(ACT_ARRIVE, ID_W'($urandom), b));
      end
    end
  endtask

  logic [CFG_W-1:0] slice_set [5] = '{8'd4, 8'd1, 8'd255, 8'd3, 8'd2};
  logic [CFG_W-1:0] ovh_set   [5] = '{8'd0, 8'd255, 8'd16, 8'd1, 8'd128};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.job_id = '0;
    in_ch.burst_length = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TIME_SLICE;
    cfg_ch.data = '0;
    q_head = 0;
    q_count = 0;
    running = '{default: '0};
    running_valid = 1'b0;
    tick_cnt = '0;
    slice_cnt = '0;
    switch_cnt = '0;
    quantum = TIME_SLICE_RST;
    overhead = SWITCH_OVH_RST;
    acc_in = 0;
    acc_out = 0;
    err_cnt = 0;
    hold_left = 0;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_TIME_SLICE, slice_set[p]);
      write_reg(REG_SWITCH_OVH, ovh_set[p]);
      if (p == 0) begin
        // tick on an empty block, zero burst, widest burst, rotation, full queue
        job_q.push_back(mk_req(ACT_TICK, 8'hff, 16'hffff));
        job_q.push_back(mk_req(ACT_ARRIVE, 8'h00, 16'h0000));
        job_q.push_back(mk_req(ACT_TICK, 8'h00, 16'h0000));
        job_q.push_back(mk_req(ACT_ARRIVE, 8'hff, 16'hffff));
        job_q.push_back(mk_req(ACT_ARRIVE, 8'h07, 16'h0001));
        repeat (4) job_q.push_back(mk_req(ACT_TICK, 8'h00, 16'h0000));
        for (int i = 0; i < 16; i++)
          job_q.push_back(mk_req(ACT_ARRIVE, ID_W'(8'h10 + i), BURST_W'(1 + i % 3)));
      end
      queue_random(RAND_ITEMS);
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
